>>> sv/assert_macros.svh
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> sv/fzaf_pkg.sv
// Package with table depth, register codes and the exp and logistic tables.
`timescale 1ns / 1ps
package fzaf_pkg;
    localparam int DEPTH = 256;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [63:0] TAB_STEP = (64'd16 << 30) / DEPTH;

    typedef logic [15:0] t_tab [DEPTH];

    typedef enum logic [2:0] {
        REG_EXO_NEG   = 3'd0,
        REG_EXO_POS   = 3'd1,
        REG_EXO_ZERO  = 3'd2,
        REG_HUM_NEG   = 3'd3,
        REG_HUM_POS   = 3'd4,
        REG_SCALES    = 3'd5,
        REG_WEIGHTS   = 3'd6
    } t_reg;

    // Shift-and-subtract quotient, used only while the tables are elaborated.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= 65'(dvs)) begin
                rem  = rem - 65'(dvs);
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Builds exp(-t) in Q2.14, or the logistic 1/(1+exp(-t)) when logistic is set.
    function automatic t_tab build_table(input logic logistic);
        logic [63:0]        h;
        logic [63:0]        term;
        logic [63:0]        e;
        logic [63:0]        r;
        logic [63:0]        den;
        logic signed [63:0] sum;
        t_tab               t;
        h    = TAB_STEP;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        e    = 64'd1 << 30;
        for (int n = 1; n <= 24; n++) begin
            term = udiv64((term * h) >> 30, 64'(n));
            if (n % 2 == 1) sum = sum - $signed(term);
            else            sum = sum + $signed(term);
        end
        r = $unsigned(sum);
        for (int k = 0; k < DEPTH; k++) begin
            den = (64'd1 << 30) + e;
            if (logistic) t[k] = 16'(udiv64((64'd1 << 44) + (den >> 1), den));
            else          t[k] = 16'((e + (64'd1 << 15)) >> 16);
            e = (e * r) >> 30;
        end
        return t;
    endfunction

    localparam t_tab EXP_TAB  = build_table(1'b0);
    localparam t_tab LOGI_TAB = build_table(1'b1);
endpackage

>>> sv/fzaf_gauss.sv
// Four-stage Gaussian membership unit: difference, square, width, table lookup.
`timescale 1ns / 1ps
module fzaf_gauss (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_x,
    input  logic [31:0]        i_shape,
    output logic [15:0]        o_g
);
    import fzaf_pkg::*;

    logic signed [16:0] r_d;
    logic [31:0]        r_d2;
    logic [47:0]        r_arg;
    logic signed [33:0] n_sq;
    logic [63:0]        n_idx;

    assign n_sq  = r_d * r_d;
    assign n_idx = (64'(r_arg) * 64'(DEPTH) + (64'd1 << 39)) >> 40;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d   <= 17'(i_x) - 17'($signed(i_shape[31:16]));
            r_d2  <= n_sq[31:0];
            r_arg <= 48'(r_d2) * 48'(i_shape[15:0]);
            // Arguments past the end of the table give no membership.
            o_g   <= (n_idx >= 64'(DEPTH)) ? 16'd0 : EXP_TAB[n_idx[IDX_W-1:0]];
        end
    end
endmodule

>>> sv/fzaf_sigm.sv
// Four-stage sigmoid membership unit: difference, slope, magnitude, table lookup.
`timescale 1ns / 1ps
module fzaf_sigm (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_x,
    input  logic [31:0]        i_shape,
    output logic [15:0]        o_s
);
    import fzaf_pkg::*;

    logic signed [16:0] r_dt;
    logic signed [32:0] r_z;
    logic [32:0]        r_mag;
    logic               r_neg;
    logic [63:0]        n_idx;
    logic [15:0]        n_l;

    assign n_idx = (64'(r_mag) * 64'(DEPTH) + (64'd1 << 23)) >> 24;
    assign n_l   = (n_idx >= 64'(DEPTH)) ? 16'd16384 : LOGI_TAB[n_idx[IDX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dt  <= 17'(i_x) - 17'($signed(i_shape[31:16]));
            r_z   <= 33'($signed(i_shape[15:0]) * r_dt);
            r_neg <= r_z[32];
            r_mag <= r_z[32] ? 33'(-r_z) : 33'(r_z);
            o_s   <= r_neg ? 16'(16'd16384 - n_l) : n_l;
        end
    end
endmodule

>>> sv/fuzzy_assistance_factor.sv
// Top level of the fuzzy assistance factor pipeline with its register port.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | human_torque, desired_position
//  m_      | out | m_tvalid/m_tready  | assistance, assist_strength, resist_strength
//  apb     | in  | psel/penable       | seven 32-bit registers at 4*i
//
// Ten register stages: an item enters every cycle unless the output is stalled.
// The membership units take four stages, the rule arithmetic six; at most one multiplier level each.
// A stall on the output freezes every stage at once, so nothing is dropped or repeated.
// Reset clears the stage valid bits and the configuration registers; data stages are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fuzzy_assistance_factor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] human_torque, [31:16] desired_position
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] assistance, [31:16] assist_strength,
                                   // [47:32] resist_strength
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fzaf_pkg::*;

    localparam int NSTG = 10;

    logic [31:0] r_exo_neg, r_exo_pos, r_exo_zero, r_hum_neg, r_hum_pos, r_scales, r_weights;
    logic [NSTG-1:0] r_vld;
    logic        adv;
    logic [15:0] g_neg, g_pos, g_zero, s_neg, s_pos;
    logic [15:0] s0, s1, pa, pr;
    logic [16:0] r_m0, r_m1, r_zt, r_m4, r_m5;
    logic [16:0] r6_m0, r6_m1, r6_m4, r6_m5;
    logic [17:0] r_m2, r_m3;
    logic [19:0] r_r0, r_r1, r_r2, r_r3;
    logic [15:0] r_lam_a, r_lam_r, r9_lam_a, r9_lam_r;
    logic [31:0] r_pa_l, r_pr_l;
    logic [15:0] r_assist, r_out_a, r_out_r;
    logic [33:0] n_wsum;
    logic signed [34:0] n_assist;
    logic [20:0] n_lam_a, n_lam_r;
    t_reg        wr_reg;

    // The mixed-set strengths reach eighteen bits, so the product keeps bits up to 33.
    function automatic logic [19:0] mulq14(input logic [17:0] a, input logic [17:0] b);
        logic [35:0] p;
        p = 36'(a) * 36'(b) + 36'd8192;
        return p[33:14];
    endfunction

    assign s0 = r_scales[31:16];
    assign s1 = r_scales[15:0];
    assign pa = r_weights[31:16];
    assign pr = r_weights[15:0];

    assign adv      = !r_vld[NSTG-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = r_vld[NSTG-1];
    assign m_tdata  = {r_out_r, r_out_a, r_assist};
    assign pready   = 1'b1;
    assign wr_reg   = t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exo_neg  <= '0;
            r_exo_pos  <= '0;
            r_exo_zero <= '0;
            r_hum_neg  <= '0;
            r_hum_pos  <= '0;
            r_scales   <= '0;
            r_weights  <= '0;
        end else if (psel && penable && pwrite) begin
            case (wr_reg)
                REG_EXO_NEG:  r_exo_neg  <= pwdata;
                REG_EXO_POS:  r_exo_pos  <= pwdata;
                REG_EXO_ZERO: r_exo_zero <= pwdata;
                REG_HUM_NEG:  r_hum_neg  <= pwdata;
                REG_HUM_POS:  r_hum_pos  <= pwdata;
                REG_SCALES:   r_scales   <= pwdata;
                REG_WEIGHTS:  r_weights  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wr_reg)
            REG_EXO_NEG:  prdata = r_exo_neg;
            REG_EXO_POS:  prdata = r_exo_pos;
            REG_EXO_ZERO: prdata = r_exo_zero;
            REG_HUM_NEG:  prdata = r_hum_neg;
            REG_HUM_POS:  prdata = r_hum_pos;
            REG_SCALES:   prdata = r_scales;
            REG_WEIGHTS:  prdata = r_weights;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], s_tvalid};
        end
    end

    fzaf_gauss u_g_neg (.i_clk(i_clk), .i_en(adv), .i_x($signed(s_tdata[31:16])),
                        .i_shape(r_exo_neg), .o_g(g_neg));
    fzaf_gauss u_g_pos (.i_clk(i_clk), .i_en(adv), .i_x($signed(s_tdata[31:16])),
                        .i_shape(r_exo_pos), .o_g(g_pos));
    fzaf_gauss u_g_zero (.i_clk(i_clk), .i_en(adv), .i_x($signed(s_tdata[31:16])),
                         .i_shape(r_exo_zero), .o_g(g_zero));
    fzaf_sigm u_s_neg (.i_clk(i_clk), .i_en(adv), .i_x($signed(s_tdata[15:0])),
                       .i_shape(r_hum_neg), .o_s(s_neg));
    fzaf_sigm u_s_pos (.i_clk(i_clk), .i_en(adv), .i_x($signed(s_tdata[15:0])),
                       .i_shape(r_hum_pos), .o_s(s_pos));

    assign n_lam_a  = 21'(r_r0) + 21'(r_r1);
    assign n_lam_r  = 21'(r_r2) + 21'(r_r3);
    assign n_wsum   = (34'(r_pa_l) + 34'(r_pr_l) + 34'd8192) >> 14;
    assign n_assist = 35'sd16384 - $signed({1'b0, n_wsum});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m0  <= 17'(mulq14(18'(s0), 18'(g_neg)));
            r_m1  <= 17'(mulq14(18'(s0), 18'(g_pos)));
            r_zt  <= 17'(mulq14(18'(s1), 18'(g_zero)));
            r_m4  <= 17'(mulq14(18'(s0), 18'(s_neg)));
            r_m5  <= 17'(mulq14(18'(s0), 18'(s_pos)));
            r_m2  <= 18'(r_m0) + 18'(r_zt);
            r_m3  <= 18'(r_m1) + 18'(r_zt);
            r6_m0 <= r_m0;
            r6_m1 <= r_m1;
            r6_m4 <= r_m4;
            r6_m5 <= r_m5;
            r_r0  <= mulq14(18'(r6_m0), 18'(r6_m4));
            r_r1  <= mulq14(18'(r6_m1), 18'(r6_m5));
            r_r2  <= mulq14(r_m2, 18'(r6_m5));
            r_r3  <= mulq14(r_m3, 18'(r6_m4));
            r_lam_a <= (n_lam_a > 21'd65535) ? 16'hFFFF : n_lam_a[15:0];
            r_lam_r <= (n_lam_r > 21'd65535) ? 16'hFFFF : n_lam_r[15:0];
            r_pa_l  <= 32'(pa) * 32'(r_lam_a);
            r_pr_l  <= 32'(pr) * 32'(r_lam_r);
            r9_lam_a <= r_lam_a;
            r9_lam_r <= r_lam_r;
            // Only the negative side can overflow the output range.
            r_assist <= (n_assist < -35'sd32768) ? 16'h8000 : n_assist[15:0];
            r_out_a  <= r9_lam_a;
            r_out_r  <= r9_lam_r;
        end
    end

    `ASSERT_CLK(a_adv_moves, i_clk, i_rst_n, r_vld[0] && adv |=> r_vld[1], "stage lost an item")
    `ASSERT_CLK(a_stall_holds, i_clk, i_rst_n, !adv |=> $stable(r_vld), "stall changed pipe")
    `ASSERT_NEVER(a_assist_max, i_clk, i_rst_n,
                  m_tvalid && $signed(r_assist) > 16'sd16384, "assistance above one")
endmodule
